/* rtl/core/i2c_bit_master_core_macros.svh */
// assertion macros for the i2c bit master core
`ifndef I2C_BIT_MASTER_CORE_MACROS_SVH
`define I2C_BIT_MASTER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define I2CBM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("i2c bit master check failed");
`define I2CBM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("i2c bit master check failed");
`else
`define I2CBM_ASSERT(lbl, clk, rst, prop)
`define I2CBM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/i2cbm_pkg.sv */
// types and constants shared by the i2c bit master modules
package i2cbm_pkg;

  localparam int CPU_W   = 10;
  localparam int POLL_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 1'b1;

  localparam logic [CPU_W-1:0]  CYCLES_PER_US_RST  = 10'd72;
  localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

  localparam logic [2:0] REQ_START    = 3'd0;
  localparam logic [2:0] REQ_STOP     = 3'd1;
  localparam logic [2:0] REQ_WRITE    = 3'd2;
  localparam logic [2:0] REQ_READ     = 3'd3;
  localparam logic [2:0] REQ_WAIT_ACK = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    ST_A    = 5'd1,
    ST_B    = 5'd2,
    ST_C    = 5'd3,
    ST_D    = 5'd4,
    SP_A    = 5'd5,
    SP_B    = 5'd6,
    SP_C    = 5'd7,
    WR_A    = 5'd8,
    WR_B    = 5'd9,
    WR_C    = 5'd10,
    WR_END  = 5'd11,
    RD_A    = 5'd12,
    RD_B    = 5'd13,
    RD_C    = 5'd14,
    AK_A    = 5'd15,
    AK_B    = 5'd16,
    AK_C    = 5'd17,
    WA_A    = 5'd18,
    WA_B    = 5'd19,
    WA_POLL = 5'd20
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [CPU_W-1:0]  prescale;
    logic [2:0]        delay;
    logic [3:0]        bit_index;
    logic [7:0]        shift;
    logic [POLL_W-1:0] poll;
    logic              scl;
    logic              sda;
    logic              oe;
    logic [7:0]        rx_hold;
    logic              ack_latch;
    logic              err_pending;
  } st_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_oe;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

endpackage

/* rtl/core/i2c_bit_master_core.sv */
// i2c bit master core: one item is one clock step of the bus engine
//
// each item on the input channel (in_valid/in_ready) carries a command
// offer (cmd_valid, req_type, tx_byte, ack_after_read) and the sampled
// sda_in level; it advances the engine by one step and yields exactly one
// result item on the output channel (out_valid/out_ready) with the line
// levels, busy, the done pulse, the last read byte and the ack error flag
// the result of an item is registered when the item is accepted and shown in the next cycle
// throughput: one item per cycle unless stalled, set by the single result register
// in front of the receiver; the step logic runs in one pass between the
// engine state registers and that register
// a stalled receiver holds the result; in_ready stays high while the
// result register is empty or being taken, so the engine only pauses
// when a result waits and the receiver is not ready
// bus timing counts items: a phase of n us takes n * cycles_per_us items
// reset clears the engine to idle with scl and sda high and driven, loads
// cycles_per_us 72 and ack_poll_limit 250, and empties the result register
// cfg_we writes cfg_data to register cfg_index in the same cycle
`include "i2c_bit_master_core_macros.svh"

module i2c_bit_master_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [i2cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd_valid,
  input  logic [2:0]                           req_type,
  input  logic [7:0]                           tx_byte,
  input  logic                                 ack_after_read,
  input  logic                                 sda_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 scl,
  output logic                                 sda_out,
  output logic                                 sda_oe,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [7:0]                           rx_byte,
  output logic                                 ack_error
);

  logic [i2cbm_pkg::CPU_W-1:0]  cycles_per_us;
  logic [i2cbm_pkg::POLL_W-1:0] ack_poll_limit;
  i2cbm_pkg::st_t               st;
  i2cbm_pkg::st_t               st_next;
  i2cbm_pkg::res_t              res_step;
  i2cbm_pkg::res_t              res_q;
  logic                         in_accept;

  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_us  <= i2cbm_pkg::CYCLES_PER_US_RST;
      ack_poll_limit <= i2cbm_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cbm_pkg::REG_CYCLES_PER_US:  cycles_per_us  <= cfg_data;
        i2cbm_pkg::REG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data[i2cbm_pkg::POLL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= i2cbm_pkg::PH_IDLE;
      st.prescale    <= '0;
      st.delay       <= '0;
      st.bit_index   <= '0;
      st.shift       <= '0;
      st.poll        <= '0;
      st.scl         <= 1'b1;
      st.sda         <= 1'b1;
      st.oe          <= 1'b1;
      st.rx_hold     <= '0;
      st.ack_latch   <= 1'b0;
      st.err_pending <= 1'b0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  i2cbm_step u_step (
    .st             (st),
    .cmd_valid      (cmd_valid),
    .req_type       (req_type),
    .tx_byte        (tx_byte),
    .ack_after_read (ack_after_read),
    .sda_in         (sda_in),
    .cycles_per_us  (cycles_per_us),
    .ack_poll_limit (ack_poll_limit),
    .st_next        (st_next),
    .res            (res_step)
  );

  i2cbm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .res_in    (res_step),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign scl       = res_q.scl;
  assign sda_out   = res_q.sda_out;
  assign sda_oe    = res_q.sda_oe;
  assign busy_res  = res_q.busy;
  assign done_res  = res_q.done;
  assign rx_byte   = res_q.rx_byte;
  assign ack_error = res_q.ack_error;

  `I2CBM_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready)
  `I2CBM_ASSERT(a_done_not_busy, clk, rst, (out_valid && res_q.done) |-> !res_q.busy)
  `I2CBM_ASSERT(a_err_with_done, clk, rst, (out_valid && res_q.ack_error) |-> res_q.done)
  `I2CBM_ASSERT(a_cmd_starts, clk, rst, (in_accept && st.phase == i2cbm_pkg::PH_IDLE && cmd_valid && req_type <= i2cbm_pkg::REQ_WAIT_ACK) |=> (st.phase != i2cbm_pkg::PH_IDLE && out_valid && res_q.busy))
  `I2CBM_ASSERT(a_state_holds, clk, rst, !in_accept |=> $stable(st))

endmodule

/* rtl/core/i2cbm_step.sv */
// next-state and result logic for one clock step of the bit engine
module i2cbm_step (
  input  i2cbm_pkg::st_t                     st,
  input  logic                               cmd_valid,
  input  logic [2:0]                         req_type,
  input  logic [7:0]                         tx_byte,
  input  logic                               ack_after_read,
  input  logic                               sda_in,
  input  logic [i2cbm_pkg::CPU_W-1:0]        cycles_per_us,
  input  logic [i2cbm_pkg::POLL_W-1:0]       ack_poll_limit,
  output i2cbm_pkg::st_t                     st_next,
  output i2cbm_pkg::res_t                    res
);

  function automatic i2cbm_pkg::st_t enter_ph(i2cbm_pkg::st_t s, i2cbm_pkg::phase_t ph);
    i2cbm_pkg::st_t r;
    r = s;
    r.phase = ph;
    case (ph)
      i2cbm_pkg::ST_A:   begin r.oe = 1'b1; r.sda = 1'b1; r.delay = 3'd2; end
      i2cbm_pkg::ST_B:   begin r.scl = 1'b1; r.delay = 3'd5; end
      i2cbm_pkg::ST_C:   begin r.sda = 1'b0; r.delay = 3'd4; end
      i2cbm_pkg::ST_D:   begin r.scl = 1'b0; r.delay = 3'd2; end
      i2cbm_pkg::SP_A:   begin r.oe = 1'b1; r.sda = 1'b0; r.delay = 3'd2; end
      i2cbm_pkg::SP_B:   begin r.scl = 1'b1; r.delay = 3'd5; end
      i2cbm_pkg::SP_C:   begin r.sda = 1'b1; r.delay = 3'd4; end
      i2cbm_pkg::WR_A:   begin r.oe = 1'b1; r.sda = s.shift[7]; r.delay = 3'd2; end
      i2cbm_pkg::WR_B:   begin r.scl = 1'b1; r.delay = 3'd4; end
      i2cbm_pkg::WR_C:   begin r.scl = 1'b0; r.delay = 3'd2; end
      i2cbm_pkg::WR_END: begin r.scl = 1'b0; r.delay = 3'd2; end
      i2cbm_pkg::RD_A:   begin r.oe = 1'b0; r.scl = 1'b0; r.delay = 3'd5; end
      i2cbm_pkg::RD_B:   begin r.scl = 1'b1; r.delay = 3'd2; end
      i2cbm_pkg::RD_C:   begin r.delay = 3'd2; end
      i2cbm_pkg::AK_A:   begin
        r.scl = 1'b0; r.oe = 1'b1; r.sda = ~s.ack_latch; r.delay = 3'd2;
      end
      i2cbm_pkg::AK_B:   begin r.scl = 1'b1; r.delay = 3'd4; end
      i2cbm_pkg::AK_C:   begin r.scl = 1'b0; r.delay = 3'd2; end
      i2cbm_pkg::WA_A:   begin r.oe = 1'b0; r.sda = 1'b1; r.delay = 3'd2; end
      i2cbm_pkg::WA_B:   begin r.scl = 1'b1; r.delay = 3'd2; end
      default:           begin r.delay = 3'd0; end
    endcase
    return r;
  endfunction

  i2cbm_pkg::st_t n;
  logic           tick;
  logic           done_now;
  logic           err_now;

  always_comb begin
    n        = st;
    tick     = 1'b0;
    done_now = 1'b0;
    err_now  = 1'b0;
    if (st.phase == i2cbm_pkg::PH_IDLE) begin
      if (cmd_valid && (req_type <= i2cbm_pkg::REQ_WAIT_ACK)) begin
        n.prescale    = '0;
        n.poll        = '0;
        n.bit_index   = '0;
        n.err_pending = 1'b0;
        case (req_type)
          i2cbm_pkg::REQ_START: n = enter_ph(n, i2cbm_pkg::ST_A);
          i2cbm_pkg::REQ_STOP:  n = enter_ph(n, i2cbm_pkg::SP_A);
          i2cbm_pkg::REQ_WRITE: begin
            n.shift = tx_byte;
            n = enter_ph(n, i2cbm_pkg::WR_A);
          end
          i2cbm_pkg::REQ_READ: begin
            n.shift     = '0;
            n.ack_latch = ack_after_read;
            n = enter_ph(n, i2cbm_pkg::RD_A);
          end
          default: n = enter_ph(n, i2cbm_pkg::WA_A);
        endcase
      end
    end else begin
      if (({1'b0, st.prescale} + 11'd1) >= {1'b0, cycles_per_us}) begin
        n.prescale = '0;
        tick       = 1'b1;
      end else begin
        n.prescale = st.prescale + 10'd1;
      end
      if (tick) begin
        if (n.phase == i2cbm_pkg::WA_POLL) begin
          if (!sda_in) begin
            n.scl    = 1'b0;
            n.phase  = i2cbm_pkg::PH_IDLE;
            n.delay  = 3'd0;
            done_now = 1'b1;
          end else begin
            n.poll = st.poll + 8'd1;
            if (n.poll >= ack_poll_limit) begin
              n.err_pending = 1'b1;
              n = enter_ph(n, i2cbm_pkg::SP_A);
            end
          end
        end else begin
          if (n.delay != 3'd0) n.delay = n.delay - 3'd1;
          if (n.delay == 3'd0) begin
            case (n.phase)
              i2cbm_pkg::ST_A: n = enter_ph(n, i2cbm_pkg::ST_B);
              i2cbm_pkg::ST_B: n = enter_ph(n, i2cbm_pkg::ST_C);
              i2cbm_pkg::ST_C: n = enter_ph(n, i2cbm_pkg::ST_D);
              i2cbm_pkg::SP_A: n = enter_ph(n, i2cbm_pkg::SP_B);
              i2cbm_pkg::SP_B: n = enter_ph(n, i2cbm_pkg::SP_C);
              i2cbm_pkg::SP_C: begin
                n.phase  = i2cbm_pkg::PH_IDLE;
                done_now = 1'b1;
                err_now  = n.err_pending;
              end
              i2cbm_pkg::WR_A: n = enter_ph(n, i2cbm_pkg::WR_B);
              i2cbm_pkg::WR_B: n = enter_ph(n, i2cbm_pkg::WR_C);
              i2cbm_pkg::WR_C: begin
                n.shift     = {n.shift[6:0], 1'b0};
                n.bit_index = n.bit_index + 4'd1;
                n = enter_ph(n, (n.bit_index >= 4'd8) ? i2cbm_pkg::WR_END
                                                      : i2cbm_pkg::WR_A);
              end
              i2cbm_pkg::RD_A: n = enter_ph(n, i2cbm_pkg::RD_B);
              i2cbm_pkg::RD_B: begin
                n.shift = {n.shift[6:0], sda_in};
                n = enter_ph(n, i2cbm_pkg::RD_C);
              end
              i2cbm_pkg::RD_C: begin
                n.bit_index = n.bit_index + 4'd1;
                n = enter_ph(n, (n.bit_index >= 4'd8) ? i2cbm_pkg::AK_A
                                                      : i2cbm_pkg::RD_A);
              end
              i2cbm_pkg::AK_A: n = enter_ph(n, i2cbm_pkg::AK_B);
              i2cbm_pkg::AK_B: n = enter_ph(n, i2cbm_pkg::AK_C);
              i2cbm_pkg::AK_C: begin
                n.rx_hold = n.shift;
                n.phase   = i2cbm_pkg::PH_IDLE;
                done_now  = 1'b1;
              end
              i2cbm_pkg::WA_A: n = enter_ph(n, i2cbm_pkg::WA_B);
              i2cbm_pkg::WA_B: n = enter_ph(n, i2cbm_pkg::WA_POLL);
              default: begin
                n.phase  = i2cbm_pkg::PH_IDLE;
                done_now = 1'b1;
              end
            endcase
            if (done_now) n.delay = 3'd0;
          end
        end
      end
    end
  end

  assign st_next       = n;
  assign res.scl       = n.scl;
  assign res.sda_out   = n.sda;
  assign res.sda_oe    = n.oe;
  assign res.busy      = (n.phase != i2cbm_pkg::PH_IDLE);
  assign res.done      = done_now;
  assign res.rx_byte   = n.rx_hold;
  assign res.ack_error = err_now;

endmodule

/* rtl/core/i2cbm_out_stage.sv */
// result register with valid and ready toward the receiver
module i2cbm_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  i2cbm_pkg::res_t res_in,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cbm_pkg::res_t res_out
);

  logic            valid;
  i2cbm_pkg::res_t data;

  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign res_out   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res_in;
    end
  end

endmodule

/* sim/i2cbm_bus_checker.sv */
// checker for the i2c bit master core: predicts each result item and compares it field by field
`timescale 1ns / 1ps

module i2cbm_bus_checker
  import i2cbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  cmd_valid,
  input  logic [2:0]            req_type,
  input  logic [7:0]            tx_byte,
  input  logic                  ack_after_read,
  input  logic                  sda_in,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  scl,
  input  logic                  sda_out,
  input  logic                  sda_oe,
  input  logic                  busy_res,
  input  logic                  done_res,
  input  logic [7:0]            rx_byte,
  input  logic                  ack_error,
  output int                    pending,
  output int                    fails
);

  logic [CPU_W-1:0]  cpu_cfg;
  logic [POLL_W-1:0] poll_cfg;

  phase_t            ph;
  logic [CPU_W-1:0]  pre_cnt;
  logic [2:0]        us_left;
  logic [3:0]        bit_cnt;
  logic [7:0]        shreg;
  logic [POLL_W-1:0] poll_cnt;
  logic              scl_q;
  logic              sda_q;
  logic              oe_q;
  logic [7:0]        rx_q;
  logic              ack_q;
  logic              err_q;
  logic              done_now;
  logic              err_now;

  res_t bus_state_q[$];

  function automatic void reset_model();
    cpu_cfg  = CYCLES_PER_US_RST;
    poll_cfg = ACK_POLL_LIMIT_RST;
    ph       = PH_IDLE;
    pre_cnt  = '0;
    us_left  = '0;
    bit_cnt  = '0;
    shreg    = '0;
    poll_cnt = '0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
    oe_q     = 1'b1;
    rx_q     = '0;
    ack_q    = 1'b0;
    err_q    = 1'b0;
  endfunction

  function automatic void enter_phase(phase_t p);
    ph = p;
    case (p)
      ST_A:         begin oe_q = 1'b1; sda_q = 1'b1; us_left = 3'd2; end
      ST_B:         begin scl_q = 1'b1; us_left = 3'd5; end
      ST_C:         begin sda_q = 1'b0; us_left = 3'd4; end
      ST_D:         begin scl_q = 1'b0; us_left = 3'd2; end
      SP_A:         begin oe_q = 1'b1; sda_q = 1'b0; us_left = 3'd2; end
      SP_B:         begin scl_q = 1'b1; us_left = 3'd5; end
      SP_C:         begin sda_q = 1'b1; us_left = 3'd4; end
      WR_A:         begin oe_q = 1'b1; sda_q = shreg[7]; us_left = 3'd2; end
      WR_B:         begin scl_q = 1'b1; us_left = 3'd4; end
      WR_C, WR_END: begin scl_q = 1'b0; us_left = 3'd2; end
      RD_A:         begin oe_q = 1'b0; scl_q = 1'b0; us_left = 3'd5; end
      RD_B:         begin scl_q = 1'b1; us_left = 3'd2; end
      RD_C:         us_left = 3'd2;
      AK_A:         begin scl_q = 1'b0; oe_q = 1'b1; sda_q = ~ack_q; us_left = 3'd2; end
      AK_B:         begin scl_q = 1'b1; us_left = 3'd4; end
      AK_C:         begin scl_q = 1'b0; us_left = 3'd2; end
      WA_A:         begin oe_q = 1'b0; sda_q = 1'b1; us_left = 3'd2; end
      WA_B:         begin scl_q = 1'b1; us_left = 3'd2; end
      default:      us_left = 3'd0;
    endcase
  endfunction

  function automatic void end_cmd(logic e);
    ph       = PH_IDLE;
    us_left  = 3'd0;
    done_now = 1'b1;
    err_now  = e;
  endfunction

  function automatic void advance_phase(logic s);
    case (ph)
      ST_A: enter_phase(ST_B);
      ST_B: enter_phase(ST_C);
      ST_C: enter_phase(ST_D);
      ST_D: end_cmd(1'b0);
      SP_A: enter_phase(SP_B);
      SP_B: enter_phase(SP_C);
      SP_C: end_cmd(err_q);
      WR_A: enter_phase(WR_B);
      WR_B: enter_phase(WR_C);
      WR_C: begin
        shreg   = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) enter_phase(WR_END);
        else enter_phase(WR_A);
      end
      WR_END: end_cmd(1'b0);
      RD_A: enter_phase(RD_B);
      RD_B: begin
        shreg = {shreg[6:0], s};
        enter_phase(RD_C);
      end
      RD_C: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) enter_phase(AK_A);
        else enter_phase(RD_A);
      end
      AK_A: enter_phase(AK_B);
      AK_B: enter_phase(AK_C);
      AK_C: begin
        rx_q = shreg;
        end_cmd(1'b0);
      end
      WA_A: enter_phase(WA_B);
      WA_B: enter_phase(WA_POLL);
      default: end_cmd(1'b0);
    endcase
  endfunction

  // one microsecond tick of the bus timing
  function automatic void us_tick(logic s);
    if (ph == WA_POLL) begin
      if (!s) begin
        scl_q = 1'b0;
        end_cmd(1'b0);
      end else begin
        poll_cnt = poll_cnt + 1'b1;
        if (poll_cnt >= poll_cfg) begin
          err_q = 1'b1;
          enter_phase(SP_A);
        end
      end
    end else begin
      if (us_left != 3'd0) us_left = us_left - 3'd1;
      if (us_left == 3'd0) advance_phase(s);
    end
  endfunction

  function automatic res_t predict_bus_step(logic cv, logic [2:0] req, logic [7:0] txb,
                                            logic ackr, logic s);
    res_t r;
    done_now = 1'b0;
    err_now  = 1'b0;
    if (ph == PH_IDLE) begin
      if (cv && req <= REQ_WAIT_ACK) begin
        pre_cnt  = '0;
        poll_cnt = '0;
        bit_cnt  = '0;
        err_q    = 1'b0;
        case (req)
          REQ_START: enter_phase(ST_A);
          REQ_STOP:  enter_phase(SP_A);
          REQ_WRITE: begin
            shreg = txb;
            enter_phase(WR_A);
          end
          REQ_READ: begin
            shreg = '0;
            ack_q = ackr;
            enter_phase(RD_A);
          end
          default: enter_phase(WA_A);
        endcase
      end
    end else if ({1'b0, pre_cnt} + 11'd1 >= {1'b0, cpu_cfg}) begin
      pre_cnt = '0;
      us_tick(s);
    end else begin
      pre_cnt = pre_cnt + 1'b1;
    end
    r.scl       = scl_q;
    r.sda_out   = sda_q;
    r.sda_oe    = oe_q;
    r.busy      = (ph != PH_IDLE);
    r.done      = done_now;
    r.rx_byte   = rx_q;
    r.ack_error = err_now;
    return r;
  endfunction

  function automatic int field_bad(string fname, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int   bad;
    int   push;
    int   pop;
    bad  = 0;
    push = 0;
    pop  = 0;
    if (rst) begin
      reset_model();
      bus_state_q.delete();
      pending <= 0;
      fails   <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CYCLES_PER_US) cpu_cfg = cfg_data[CPU_W-1:0];
        else if (cfg_index == REG_ACK_POLL_LIMIT) poll_cfg = cfg_data[POLL_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (bus_state_q.size() == 0) begin
          $error("result item with nothing expected");
          bad = 1;
        end else begin
          want = bus_state_q.pop_front();
          pop  = 1;
          bad += field_bad("scl", want.scl, scl);
          bad += field_bad("sda_out", want.sda_out, sda_out);
          bad += field_bad("sda_oe", want.sda_oe, sda_oe);
          bad += field_bad("busy_res", want.busy, busy_res);
          bad += field_bad("done_res", want.done, done_res);
          bad += field_bad("rx_byte", want.rx_byte, rx_byte);
          bad += field_bad("ack_error", want.ack_error, ack_error);
        end
      end
      if (in_valid && in_ready) begin
        bus_state_q.push_back(predict_bus_step(cmd_valid, req_type, tx_byte,
                                               ack_after_read, sda_in));
        push = 1;
      end
      pending <= pending + push - pop;
      fails   <= fails + bad;
    end
  end

endmodule

/* sim/tb.sv */
// testbench top for the i2c bit master core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import i2cbm_pkg::*;

  localparam logic [2:0] REQ_RSVD_5 = 3'd5;
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = REG_CYCLES_PER_US;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  cmd_valid      = 1'b0;
  logic [2:0]            req_type       = REQ_START;
  logic [7:0]            tx_byte        = '0;
  logic                  ack_after_read = 1'b0;
  logic                  sda_in         = 1'b1;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  scl;
  logic                  sda_out;
  logic                  sda_oe;
  logic                  busy_res;
  logic                  done_res;
  logic [7:0]            rx_byte;
  logic                  ack_error;
  int                    pending;
  int                    fails;

  int   gap_pct     = 15;
  int   sda_low_pct = 10;
  bit   quiet       = 1'b0;
  bit   hold_req    = 1'b0;
  logic seen_busy   = 1'b0;

  always #4 clk = ~clk;

  i2c_bit_master_core u_dut (.*);

  i2cbm_bus_checker u_chk (.*);

  always @(posedge clk) begin
    if (out_valid && out_ready) seen_busy <= busy_res;
  end

  function automatic logic [2:0] pick_req();
    int r;
    r = $urandom_range(0, 15);
    if (r < 13) return 3'(r % 5);
    return 3'(r - 8);
  endfunction

  task automatic send_step(bit cv, logic [2:0] req, logic [7:0] txb, bit ackr);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    cmd_valid      <= cv;
    req_type       <= req;
    tx_byte        <= txb;
    ack_after_read <= ackr;
    sda_in         <= ($urandom_range(0, 99) >= sda_low_pct);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // step with no command until the engine reports idle
  task automatic settle_bus();
    drain();
    while (seen_busy) begin
      repeat (8) send_step(1'b0, pick_req(), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
      drain();
    end
  endtask

  task automatic do_cmd(logic [2:0] req, logic [7:0] txb, bit ackr);
    send_step(1'b1, req, txb, ackr);
    settle_bus();
  endtask

  task automatic configure(int cpu, int plim);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CYCLES_PER_US;
    cfg_data  <= CFG_DATA_W'(cpu);
    @(posedge clk);
    cfg_index <= REG_ACK_POLL_LIMIT;
    cfg_data  <= CFG_DATA_W'(plim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n_steps, int hold_at);
    for (int i = 0; i < n_steps; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send_step($urandom_range(0, 5) == 0, pick_req(), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(0, 99) >= gap_pct) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset timing: first step of a start at the reset prescale
    send_step(1'b1, REQ_START, 8'h00, 1'b0);
    repeat (150) send_step(1'b0, pick_req(), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));

    // zero prescale and zero poll limit
    configure(0, 0);
    settle_bus();
    sda_low_pct = 0;
    do_cmd(REQ_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 50;
    send_step(1'b1, REQ_RSVD_5, 8'h00, 1'b0);
    send_step(1'b1, REQ_RSVD_6, 8'hFF, 1'b1);
    send_step(1'b1, REQ_RSVD_7, 8'h81, 1'b0);
    send_step(1'b0, REQ_WRITE, 8'h42, 1'b1);
    send_step(1'b1, REQ_START, 8'h00, 1'b0);
    send_step(1'b1, REQ_WRITE, 8'h3C, 1'b1);
    send_step(1'b1, REQ_READ, 8'hC3, 1'b0);
    settle_bus();

    configure(1, 1);
    sda_low_pct = 0;
    do_cmd(REQ_WAIT_ACK, 8'h00, 1'b0);
    sda_low_pct = 100;
    do_cmd(REQ_WAIT_ACK, 8'h00, 1'b0);

    // random traffic
    gap_pct     = 20;
    sda_low_pct = 15;
    configure(1, 3);
    random_phase(70, -1);
    sda_low_pct = 5;
    configure(2, 6);
    random_phase(70, 30);
    quiet       = 1'b1;
    sda_low_pct = 30;
    configure(1, 2);
    random_phase(70, -1);

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* i2c_bit_master_core.f */
+incdir+rtl/core
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_step.sv
rtl/core/i2cbm_out_stage.sv
rtl/core/i2c_bit_master_core.sv
sim/i2cbm_bus_checker.sv
sim/tb.sv
